// File: rtl/bfse_pkg.sv
`timescale 1ns / 1ps
package bfse_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_OUT  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] address;
    logic [7:0]  data;
    logic        data_valid;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_char;
    logic [12:0] pc_now;
    logic [15:0] line_now;
  } out_t;

  typedef struct packed {
    logic [12:0] location;
    logic [15:0] newlines;
  } stk_ent_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } tape_wr_t;

endpackage

// File: rtl/bfse_tape.sv
`timescale 1ns / 1ps
module bfse_tape #(
  parameter int TAPE_DEPTH = 4096,
  localparam int TAW = $clog2(TAPE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear_req,
  output logic               clearing,
  input  logic [TAW-1:0]     addr,
  input  bfse_pkg::tape_wr_t wr,
  output logic [7:0]         rd_data
);

  logic [7:0]     mem [TAPE_DEPTH];
  logic [TAW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr.en) begin
      mem[addr] <= wr.data;
    end
    rd_data <= mem[addr];
  end

  // sweep the whole tape to zero, one cell a cycle
  always_ff @(posedge clk) begin
    if (rst || clear_req) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == TAW'(TAPE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

endmodule

// File: rtl/brainfuck_step_engine.sv
`timescale 1ns / 1ps
// Channel   Signals                      Direction  Handshake
// item      start, item                  in         taken when start && !busy
// result    result_valid, result         out        one-cycle strobe, no stall
// config    cfg_we, cfg_data             in         written when cfg_we
//
// Load, restart-less commands and finished steps answer in the cycle after accept.
// A step reads program, tape and stack, then executes and writes back.
// A forward skip on '[' scans the program bytes after it in the skip state before it answers.
// Reset and every restart sweep the tape to zero, with busy high.
// The result side cannot stall; each result shows for exactly one cycle.
module brainfuck_step_engine #(
  parameter int PROG_DEPTH  = 4096,
  parameter int TAPE_DEPTH  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bfse_pkg::in_t  item,
  output logic           result_valid,
  output bfse_pkg::out_t result,
  input  logic           cfg_we,
  input  logic [12:0]    cfg_data
);

  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SKIP  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [12:0]  plen;
  logic [12:0]  len;
  logic [12:0]  pc, pc_next;
  logic [TAW-1:0] ptr, ptr_next;
  logic [15:0]  line, line_next;
  logic [15:0]  lsb, lsb_next;
  logic [SAW:0] top, top_next;
  logic [12:0]  scan_addr, scan_addr_next;
  logic [12:0]  depth, depth_next;
  logic [15:0]  nl, nl_next;
  bfse_pkg::in_t  req;
  bfse_pkg::out_t res_next;
  logic           res_fire;

  logic [7:0]     prog_mem [PROG_DEPTH];
  logic [7:0]     prog_q;
  logic [PAW-1:0] prog_raddr;

  bfse_pkg::stk_ent_t stk_mem [STACK_DEPTH];
  bfse_pkg::stk_ent_t stk_q;
  bfse_pkg::stk_ent_t stk_wdata;
  logic               stk_we;

  logic               accept;
  logic               clear_req;
  logic               tape_clearing;
  logic [7:0]         tape_q;
  bfse_pkg::tape_wr_t tape_wr;
  logic [12:0]        pc_inc;
  logic [12:0]        depth_step;
  logic [15:0]        nl_step;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE) || tape_clearing;
  assign clear_req = accept && (item.cmd == bfse_pkg::CMD_RESTART);
  assign len       = (32'(plen) < PROG_DEPTH) ? plen : 13'(PROG_DEPTH);
  assign pc_inc    = pc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
    end else if (cfg_we) begin
      plen <= cfg_data;
    end
  end

  bfse_tape #(.TAPE_DEPTH(TAPE_DEPTH)) u_tape (
    .clk      (clk),
    .rst      (rst),
    .clear_req(clear_req),
    .clearing (tape_clearing),
    .addr     (ptr),
    .wr       (tape_wr),
    .rd_data  (tape_q)
  );

  always_comb begin
    case (state)
      S_EXEC:  prog_raddr = PAW'(pc_inc);
      S_SKIP:  prog_raddr = PAW'(scan_addr + 1'b1);
      default: prog_raddr = PAW'(pc);
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == bfse_pkg::CMD_LOAD && 32'(item.address) < PROG_DEPTH) begin
      prog_mem[PAW'(item.address)] <= item.data;
    end
    prog_q <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[SAW'(top)] <= stk_wdata;
    end
    stk_q <= stk_mem[SAW'(top - 1'b1)];
  end

  // skip scan: track bracket depth and newlines of the byte arriving now
  always_comb begin
    depth_step = depth;
    nl_step    = nl;
    case (prog_q)
      bfse_pkg::CH_OPEN:  depth_step = depth + 1'b1;
      bfse_pkg::CH_CLOSE: depth_step = depth - 1'b1;
      bfse_pkg::CH_NL:    nl_step    = nl + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    ptr_next       = ptr;
    line_next      = line;
    lsb_next       = lsb;
    top_next       = top;
    scan_addr_next = scan_addr;
    depth_next     = depth;
    nl_next        = nl;
    stk_we         = 1'b0;
    stk_wdata      = '{location: pc, newlines: lsb};
    tape_wr        = '{en: 1'b0, data: tape_q};
    res_fire       = 1'b0;
    res_next       = '0;
    res_next.status = bfse_pkg::ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.cmd)
            bfse_pkg::CMD_STEP: begin
              if (pc >= len) begin
                res_fire        = 1'b1;
                res_next.status = bfse_pkg::ST_DONE;
              end else begin
                state_next = S_EXEC;
              end
            end
            bfse_pkg::CMD_RESTART: begin
              pc_next    = '0;
              ptr_next   = '0;
              line_next  = 16'd1;
              lsb_next   = '0;
              top_next   = '0;
              state_next = S_CLEAR;
            end
            default: res_fire = 1'b1;
          endcase
        end
      end

      S_CLEAR: begin
        if (!tape_clearing) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        res_fire   = 1'b1;
        pc_next    = pc_inc;
        case (prog_q)
          bfse_pkg::CH_PLUS:  tape_wr = '{en: 1'b1, data: tape_q + 1'b1};
          bfse_pkg::CH_MINUS: tape_wr = '{en: 1'b1, data: tape_q - 1'b1};
          bfse_pkg::CH_RIGHT:
            ptr_next = (ptr == TAW'(TAPE_DEPTH - 1)) ? '0 : ptr + 1'b1;
          bfse_pkg::CH_LEFT:
            ptr_next = (ptr == '0) ? TAW'(TAPE_DEPTH - 1) : ptr - 1'b1;
          bfse_pkg::CH_COMMA: begin
            if (req.data_valid) begin
              tape_wr = '{en: 1'b1, data: req.data};
            end else begin
              res_next.status = bfse_pkg::ST_WAIT;
              pc_next         = pc;
            end
          end
          bfse_pkg::CH_DOT: begin
            res_next.status   = bfse_pkg::ST_OUT;
            res_next.out_char = tape_q;
          end
          bfse_pkg::CH_OPEN: begin
            if (tape_q != 8'd0) begin
              if (top == (SAW + 1)'(STACK_DEPTH)) begin
                res_next.status = bfse_pkg::ST_ERR;
                pc_next         = pc;
              end else begin
                stk_we   = 1'b1;
                top_next = top + 1'b1;
                lsb_next = '0;
              end
            end else begin
              // start forward scan at the byte after this bracket
              res_fire       = 1'b0;
              pc_next        = pc;
              state_next     = S_SKIP;
              scan_addr_next = pc_inc;
              depth_next     = 13'd1;
              nl_next        = '0;
            end
          end
          bfse_pkg::CH_CLOSE: begin
            if (top == '0) begin
              res_next.status = bfse_pkg::ST_ERR;
              pc_next         = pc;
            end else begin
              top_next = top - 1'b1;
              if (tape_q != 8'd0) begin
                pc_next   = stk_q.location;
                line_next = line - stk_q.newlines;
                lsb_next  = '0;
              end else begin
                lsb_next = lsb + stk_q.newlines;
              end
            end
          end
          bfse_pkg::CH_NL: begin
            line_next = line + 1'b1;
            lsb_next  = lsb + 1'b1;
          end
          default: ;
        endcase
      end

      S_SKIP: begin
        if (scan_addr >= len) begin
          res_fire        = 1'b1;
          res_next.status = bfse_pkg::ST_ERR;
          state_next      = S_IDLE;
        end else if (depth_step == '0) begin
          res_fire   = 1'b1;
          pc_next    = scan_addr + 1'b1;
          line_next  = line + nl_step;
          lsb_next   = lsb + nl_step;
          state_next = S_IDLE;
        end else begin
          scan_addr_next = scan_addr + 1'b1;
          depth_next     = depth_step;
          nl_next        = nl_step;
        end
      end

      default: state_next = S_IDLE;
    endcase

    res_next.pc_now   = pc_next;
    res_next.line_now = line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pc           <= '0;
      ptr          <= '0;
      line         <= 16'd1;
      lsb          <= '0;
      top          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pc           <= pc_next;
      ptr          <= ptr_next;
      line         <= line_next;
      lsb          <= lsb_next;
      top          <= top_next;
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    depth     <= depth_next;
    nl        <= nl_next;
    if (accept) begin
      req <= item;
    end
    if (res_fire) begin
      result <= res_next;
    end
  end

  a_exec_from_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $past(start && !busy))
    else $error("execute state entered without an accepted item");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    top <= (SAW + 1)'(STACK_DEPTH))
    else $error("stack top beyond depth");

  a_skip_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP) |-> (depth != '0))
    else $error("skip scan running with zero bracket depth");

endmodule

// File: dv/tb_brainfuck_step_engine.sv
`timescale 1ns / 1ps
module tb_brainfuck_step_engine;

  localparam int PROG_N = 4096;
  localparam int TAPE_N = 4096;
  localparam int STACK_N = 64;
  localparam int FILL_N = 1024;
  localparam int IDLE_LIMIT = 30000;
  localparam int ITEM_TARGET = 1600;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  bfse_pkg::in_t  item = '0;
  logic           result_valid;
  bfse_pkg::out_t result;
  logic           cfg_we = 1'b0;
  logic [12:0]    cfg_data = '0;

  brainfuck_step_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // engine state as predicted
  logic [7:0]  prog_mem [PROG_N];
  logic [7:0]  tape [TAPE_N];
  logic [11:0] tape_ptr;
  logic [12:0] pc_m;
  logic [15:0] line_m;
  logic [15:0] nl_since_open;
  logic [12:0] open_loc [STACK_N];
  logic [15:0] open_nl [STACK_N];
  int          open_top;
  logic [12:0] prog_len;

  bfse_pkg::out_t expected_q [$];
  logic [7:0]     src_q [$];
  int             errors = 0;
  int             items_sent = 0;
  int             idle_cycles = 0;

  task automatic clear_run();
    for (int i = 0; i < TAPE_N; i++) tape[i] = '0;
    tape_ptr = '0;
    pc_m = '0;
    line_m = 16'd1;
    nl_since_open = '0;
    open_top = 0;
  endtask

  task automatic run_engine(input bfse_pkg::in_t it, output bfse_pkg::out_t r);
    int          eff, p, depth;
    logic [15:0] nl;
    logic [12:0] nxt;
    logic [7:0]  ch, c;
    logic        found;
    r = '0;
    r.status = bfse_pkg::ST_OK;
    case (it.cmd)
      bfse_pkg::CMD_LOAD: prog_mem[it.address] = it.data;
      bfse_pkg::CMD_RESTART: clear_run();
      bfse_pkg::CMD_STEP: begin
        eff = (prog_len > PROG_N) ? PROG_N : prog_len;
        if (pc_m >= eff) begin
          r.status = bfse_pkg::ST_DONE;
        end else begin
          ch = prog_mem[pc_m[11:0]];
          nxt = pc_m + 13'd1;
          case (ch)
            bfse_pkg::CH_PLUS: tape[tape_ptr] = tape[tape_ptr] + 8'd1;
            bfse_pkg::CH_MINUS: tape[tape_ptr] = tape[tape_ptr] - 8'd1;
            bfse_pkg::CH_RIGHT: tape_ptr = tape_ptr + 12'd1;
            bfse_pkg::CH_LEFT: tape_ptr = tape_ptr - 12'd1;
            bfse_pkg::CH_COMMA: begin
              if (it.data_valid) tape[tape_ptr] = it.data;
              else begin
                r.status = bfse_pkg::ST_WAIT;
                nxt = pc_m;
              end
            end
            bfse_pkg::CH_DOT: begin
              r.status = bfse_pkg::ST_OUT;
              r.out_char = tape[tape_ptr];
            end
            bfse_pkg::CH_OPEN: begin
              if (tape[tape_ptr] != 0) begin
                if (open_top >= STACK_N) begin
                  r.status = bfse_pkg::ST_ERR;
                  nxt = pc_m;
                end else begin
                  open_loc[open_top] = pc_m;
                  open_nl[open_top] = nl_since_open;
                  open_top++;
                  nl_since_open = '0;
                end
              end else begin
                p = pc_m;
                depth = 0;
                nl = '0;
                found = 1'b0;
                while (p < eff) begin
                  c = prog_mem[p];
                  p++;
                  if (c == bfse_pkg::CH_OPEN) depth++;
                  else if (c == bfse_pkg::CH_CLOSE) depth--;
                  else if (c == bfse_pkg::CH_NL) nl++;
                  if (depth == 0) begin
                    found = 1'b1;
                    break;
                  end
                end
                if (found) begin
                  line_m = line_m + nl;
                  nl_since_open = nl_since_open + nl;
                  nxt = 13'(p);
                end else begin
                  r.status = bfse_pkg::ST_ERR;
                  nxt = pc_m;
                end
              end
            end
            bfse_pkg::CH_CLOSE: begin
              if (open_top == 0) begin
                r.status = bfse_pkg::ST_ERR;
                nxt = pc_m;
              end else begin
                if (tape[tape_ptr] != 0) begin
                  nxt = open_loc[open_top-1];
                  line_m = line_m - open_nl[open_top-1];
                  nl_since_open = '0;
                end else begin
                  nl_since_open = nl_since_open + open_nl[open_top-1];
                end
                open_top--;
              end
            end
            bfse_pkg::CH_NL: begin
              line_m = line_m + 16'd1;
              nl_since_open = nl_since_open + 16'd1;
            end
            default: ;
          endcase
          pc_m = nxt;
        end
      end
      default: ;
    endcase
    r.pc_now = pc_m;
    r.line_now = line_m;
  endtask

  task automatic report(input string field, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    bfse_pkg::out_t e;
    if (!rst && result_valid) begin
      if (expected_q.size() == 0) begin
        report("result count", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (result.status !== e.status) report("status", result.status, e.status);
        if (result.out_char !== e.out_char) report("out_char", result.out_char, e.out_char);
        if (result.pc_now !== e.pc_now) report("pc_now", result.pc_now, e.pc_now);
        if (result.line_now !== e.line_now) report("line_now", result.line_now, e.line_now);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("brainfuck_step_engine test failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_item(input bfse_pkg::in_t it);
    bfse_pkg::out_t e;
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    run_engine(it, e);
    expected_q.push_back(e);
    items_sent++;
  endtask

  task automatic gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 65) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every expected result is back and the engine is free
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(input logic [12:0] len);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    prog_len = len;
  endtask

  task automatic load(input logic [11:0] a, input logic [7:0] d);
    bfse_pkg::in_t it;
    it = '0;
    it.cmd = bfse_pkg::CMD_LOAD;
    it.address = a;
    it.data = d;
    send_item(it);
  endtask

  task automatic step(input logic dv, input logic [7:0] d);
    bfse_pkg::in_t it;
    it = '0;
    it.cmd = bfse_pkg::CMD_STEP;
    it.data_valid = dv;
    it.data = d;
    send_item(it);
  endtask

  task automatic restart();
    bfse_pkg::in_t it;
    it = '0;
    it.cmd = bfse_pkg::CMD_RESTART;
    it.address = 12'($urandom);
    it.data = 8'($urandom);
    it.data_valid = 1'($urandom);
    send_item(it);
  endtask

  task automatic load_source(input logic [11:0] base);
    for (int i = 0; i < src_q.size(); i++) begin
      load(base + i[11:0], src_q[i]);
      gap();
    end
  endtask

  function automatic logic [7:0] filler();
    case ($urandom_range(0, 7))
      0: return bfse_pkg::CH_PLUS;
      1: return bfse_pkg::CH_MINUS;
      2: return bfse_pkg::CH_RIGHT;
      3: return bfse_pkg::CH_LEFT;
      4: return bfse_pkg::CH_DOT;
      5: return bfse_pkg::CH_NL;
      6: return bfse_pkg::CH_COMMA;
      default: return 8'h61;
    endcase
  endfunction

  task automatic test_empty_program();
    bfse_pkg::in_t it;
    step(1'b0, 8'h00);
    step(1'b1, 8'hFF);
    it = '0;
    it.cmd = bfse_pkg::CMD_NOP;
    it.address = 12'hFFF;
    it.data = 8'hFF;
    it.data_valid = 1'b1;
    send_item(it);
    gap();
    step(1'b1, 8'h00);
  endtask

  // write the low part of memory so no step can ever read an unwritten byte
  task automatic test_fill_memory();
    for (int a = 0; a < FILL_N; a++) begin
      load(a[11:0], filler());
      if ($urandom_range(0, 15) == 0) gap();
    end
  endtask

  task automatic test_every_op();
    src_q = {bfse_pkg::CH_PLUS, bfse_pkg::CH_PLUS, bfse_pkg::CH_DOT, bfse_pkg::CH_OPEN,
             bfse_pkg::CH_MINUS, bfse_pkg::CH_NL, bfse_pkg::CH_DOT, bfse_pkg::CH_CLOSE,
             bfse_pkg::CH_LEFT, bfse_pkg::CH_COMMA, bfse_pkg::CH_DOT, bfse_pkg::CH_COMMA,
             bfse_pkg::CH_DOT, bfse_pkg::CH_RIGHT, bfse_pkg::CH_RIGHT, bfse_pkg::CH_MINUS,
             bfse_pkg::CH_DOT, bfse_pkg::CH_OPEN, bfse_pkg::CH_NL, bfse_pkg::CH_PLUS,
             bfse_pkg::CH_CLOSE, 8'h00, 8'hFF};
    load_source(12'd0);
    set_length(13'(src_q.size()));
    restart();
    for (int i = 0; i < 22; i++) step(1'b0, 8'hAA);
    restart();
    for (int i = 0; i < 30; i++) begin
      step(i[0], i[1] ? 8'hFF : 8'h00);
      gap();
    end
  endtask

  task automatic test_underflow();
    src_q = {bfse_pkg::CH_CLOSE, bfse_pkg::CH_PLUS};
    load_source(12'd0);
    set_length(13'd2);
    restart();
    step(1'b0, 8'h00);
    step(1'b0, 8'h00);
  endtask

  task automatic test_overflow();
    load(12'd0, bfse_pkg::CH_PLUS);
    for (int i = 1; i <= STACK_N + 1; i++) load(i[11:0], bfse_pkg::CH_OPEN);
    set_length(13'(STACK_N + 2));
    restart();
    for (int i = 0; i < STACK_N + 3; i++) step(1'b0, 8'h00);
  endtask

  // skip across the filled region, then the same skip with its closing bracket past the program end
  task automatic test_long_skip();
    for (int a = 1; a <= STACK_N + 1; a++) load(a[11:0], filler());
    load(12'd0, bfse_pkg::CH_OPEN);
    load(12'(FILL_N - 1), bfse_pkg::CH_CLOSE);
    load(12'(FILL_N), filler());
    set_length(13'h1FFF);
    restart();
    step(1'b0, 8'h00);
    step(1'b1, 8'h00);
    set_length(13'(FILL_N - 1));
    restart();
    step(1'b0, 8'h00);
    set_length(13'(FILL_N));
    load(12'(FILL_N - 1), filler());
  endtask

  task automatic make_program(input logic broken);
    int n, depth;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(4, 30);
    depth = 0;
    src_q = {};
    if ($urandom_range(0, 1)) src_q.push_back(bfse_pkg::CH_PLUS);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: if (depth < 6) begin
          src_q.push_back(bfse_pkg::CH_OPEN);
          depth++;
        end
        1: if (depth > 0) begin
          src_q.push_back(bfse_pkg::CH_MINUS);
          src_q.push_back(bfse_pkg::CH_CLOSE);
          depth--;
        end
        2: src_q.push_back(8'($urandom));
        default: src_q.push_back(filler());
      endcase
    end
    if (broken) begin
      if ($urandom_range(0, 1)) begin
        src_q.insert($urandom_range(0, src_q.size()), bfse_pkg::CH_CLOSE);
      end else depth = 0;
    end
    while (depth > 0) begin
      src_q.push_back(bfse_pkg::CH_CLOSE);
      depth--;
    end
  endtask

  task automatic test_random_programs();
    bfse_pkg::in_t it;
    int            budget;
    while (items_sent < ITEM_TARGET) begin
      make_program($urandom_range(0, 6) == 0);
      load_source(12'd0);
      if ($urandom_range(0, 7) == 0) set_length(13'(src_q.size() + $urandom_range(1, 8)));
      else set_length(13'(src_q.size()));
      if ($urandom_range(0, 3) != 0) restart();
      else clear_run_check();
      budget = 3 * src_q.size() + 20;
      for (int s = 0; s < budget && pc_m < prog_len; s++) begin
        if ($urandom_range(0, 19) == 0) begin
          it.cmd = $urandom_range(0, 1) ? bfse_pkg::CMD_NOP : bfse_pkg::CMD_LOAD;
          it.address = 12'($urandom_range(200, 4095));
          it.data = filler();
          it.data_valid = 1'($urandom);
          send_item(it);
        end else if ($urandom_range(0, 199) == 0) restart();
        else step($urandom_range(0, 3) != 0, 8'($urandom));
        gap();
      end
      step(1'($urandom), 8'($urandom));
    end
  endtask

  // run on without a restart: carries engine state from the last program
  task automatic clear_run_check();
    step(1'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    prog_len = '0;
    for (int i = 0; i < STACK_N; i++) begin
      open_loc[i] = '0;
      open_nl[i] = '0;
    end
    for (int i = 0; i < PROG_N; i++) prog_mem[i] = '0;
    clear_run();
    @(posedge clk);
    test_empty_program();
    test_fill_memory();
    test_every_op();
    test_underflow();
    test_overflow();
    test_long_skip();
    test_random_programs();
    set_length(13'd0);
    step(1'b1, 8'h5A);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("brainfuck_step_engine test passed");
    end else begin
      $display("brainfuck_step_engine test failed");
    end
    $finish;
  end

endmodule
